FILE: design/vbd_pkg.sv
// Package for the rate 1/3, K=3 hard-decision Viterbi block decoder.
// Holds trellis tables, field widths and the branch metric function; no dependencies.
`default_nettype none

package vbd_pkg;

  localparam int unsigned WORD_W     = 24;  // coded word width
  localparam int unsigned BYTE_W     = 8;   // decoded byte width
  localparam int unsigned SYM_W      = 3;   // one code symbol
  localparam int unsigned NSTATES    = 4;
  localparam int unsigned STAGES_DEF = 8;

  // Branch k ends in state k/2; the even branch is the preferred candidate.
  // Packed with entry 0 in the low bits.
  localparam logic [7:0][1:0] BRANCH_PRED = {
    2'd3, 2'd1, 2'd3, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0
  };
  localparam logic [7:0][2:0] BRANCH_SYM = {
    3'd4, 3'd2, 3'd1, 3'd7, 3'd3, 3'd5, 3'd6, 3'd0
  };

  // Hamming distance between two 3-bit symbols.
  function automatic logic [1:0] hamming3(input logic [2:0] a, input logic [2:0] b);
    logic [2:0] x;
    x = a ^ b;
    return {1'b0, x[0]} + {1'b0, x[1]} + {1'b0, x[2]};
  endfunction

endpackage

`default_nettype wire

FILE: design/vbd_cell.sv
// One trellis stage: add-compare-select over four states plus register exchange.
// Registered output, valid/ready toward both neighbors. Depends on vbd_pkg.
`default_nettype none

module vbd_cell #(
  parameter int unsigned STAGES = vbd_pkg::STAGES_DEF,
  parameter int unsigned IDX    = 0,
  parameter int unsigned MW     = 5
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    valid_i,
  output logic                                         ready_o,
  input  wire logic [vbd_pkg::WORD_W-1:0]              word_i,
  input  wire logic [vbd_pkg::NSTATES-1:0][MW-1:0]     metric_i,
  input  wire logic [vbd_pkg::NSTATES-1:0][STAGES-1:0] hist_i,
  output logic                                         valid_o,
  input  wire logic                                    ready_i,
  output logic [vbd_pkg::WORD_W-1:0]                   word_o,
  output logic [vbd_pkg::NSTATES-1:0][MW-1:0]          metric_o,
  output logic [vbd_pkg::NSTATES-1:0][STAGES-1:0]      hist_o
);
  import vbd_pkg::*;

  localparam int unsigned LIMIT = 3 * (IDX + 1);

  logic                                valid_q;
  logic [WORD_W-1:0]                   word_q;
  logic [NSTATES-1:0][MW-1:0]          metric_q, metric_d;
  logic [NSTATES-1:0][STAGES-1:0]      hist_q, hist_d;
  logic [SYM_W-1:0]                    sym;
  logic                                load;

  // Symbols past the coded word read as zero.
  generate
    if (SYM_W * IDX + SYM_W <= WORD_W) begin : g_sym
      assign sym = word_i[SYM_W*IDX +: SYM_W];
    end else begin : g_sym_zero
      assign sym = '0;
    end
  endgenerate

  always_comb begin
    logic [MW-1:0] m0, m1;
    logic [1:0]    p0, p1, from;
    metric_d = '0;
    hist_d   = '0;
    for (int s = 0; s < NSTATES; s++) begin
      p0 = BRANCH_PRED[2*s];
      p1 = BRANCH_PRED[2*s+1];
      m0 = metric_i[p0] + MW'(hamming3(sym, BRANCH_SYM[2*s]));
      m1 = metric_i[p1] + MW'(hamming3(sym, BRANCH_SYM[2*s+1]));
      if (m0 <= m1) begin
        metric_d[s] = m0;
        from        = p0;
      end else begin
        metric_d[s] = m1;
        from        = p1;
      end
      hist_d[s]      = hist_i[from];
      hist_d[s][IDX] = (s % 2) == 1;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q   <= word_i;
      metric_q <= metric_d;
      hist_q   <= hist_d;
    end
  end

  assign valid_o  = valid_q;
  assign word_o   = word_q;
  assign metric_o = metric_q;
  assign hist_o   = hist_q;

  // Best survivor never exceeds three errors per stage seen so far.
  a_metric_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (metric_q[0] <= MW'(LIMIT) || metric_q[1] <= MW'(LIMIT) ||
                 metric_q[2] <= MW'(LIMIT) || metric_q[3] <= MW'(LIMIT)))
    else $error("vbd_cell: no survivor within metric bound");

  // Newest decided bit of each survivor equals the low bit of its state.
  a_newest_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (!hist_q[0][IDX] && hist_q[1][IDX] && !hist_q[2][IDX] && hist_q[3][IDX]))
    else $error("vbd_cell: survivor bit does not match state");

  // No bit for a later stage is set yet.
  a_future_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((hist_q[0] >> (IDX + 1)) == '0 && (hist_q[1] >> (IDX + 1)) == '0 &&
                 (hist_q[2] >> (IDX + 1)) == '0 && (hist_q[3] >> (IDX + 1)) == '0))
    else $error("vbd_cell: survivor holds bits of later stages");

endmodule

`default_nettype wire

FILE: design/vbd_pick.sv
// Final decision: lowest-numbered state with the minimum metric, into the output register.
// Depends on vbd_pkg.
`default_nettype none

module vbd_pick #(
  parameter int unsigned STAGES = vbd_pkg::STAGES_DEF,
  parameter int unsigned MW     = 5
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    valid_i,
  output logic                                         ready_o,
  input  wire logic [vbd_pkg::NSTATES-1:0][MW-1:0]     metric_i,
  input  wire logic [vbd_pkg::NSTATES-1:0][STAGES-1:0] hist_i,
  output logic                                         valid_o,
  input  wire logic                                    ready_i,
  output logic [vbd_pkg::BYTE_W-1:0]                   byte_o
);
  import vbd_pkg::*;

  logic              valid_q;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [1:0]        best;
  logic [STAGES-1:0] path;

  always_comb begin
    best = 2'd0;
    for (int s = 1; s < NSTATES; s++) begin
      if (metric_i[s] < metric_i[best]) begin
        best = 2'(s);
      end
    end
  end

  assign path = hist_i[best];

  // Stages beyond the byte are dropped; missing stages read as zero.
  generate
    for (genvar j = 0; j < BYTE_W; j++) begin : g_bit
      if (j < STAGES) begin : g_have
        assign byte_d[j] = path[j];
      end else begin : g_none
        assign byte_d[j] = 1'b0;
      end
    end
  endgenerate

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_d;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

FILE: design/viterbi_block_decoder_r13_k3_core.sv
// Viterbi block decoder, rate 1/3, K=3, hard decision, register exchange.
// Each input transaction passes through one registered cell per trellis stage,
// then the final state pick and output register.
// Throughput: one coded word per cycle unless a result stalls; every cell and the
// output register advance on their own, so a stall only holds back cells behind it.
// Reset (async, active low) clears only the valid flags; no state spans words.
`default_nettype none

module viterbi_block_decoder_r13_k3_core #(
  parameter int unsigned STAGES = vbd_pkg::STAGES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [vbd_pkg::WORD_W-1:0]  coded_word_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [vbd_pkg::BYTE_W-1:0]       decoded_byte_o
);
  import vbd_pkg::*;

  // Unreached states start at 3*STAGES+1; a candidate through an unreached state
  // gains at most 3 per stage over the first two stages, after which every
  // survivor is a real path.
  localparam int unsigned UNREACH = 3 * STAGES + 1;
  localparam int unsigned MW      = $clog2(UNREACH + 7);

  // Link g feeds cell g; link STAGES feeds the final pick.
  logic                             valid [STAGES+1];
  logic                             ready [STAGES+1];
  logic [WORD_W-1:0]                word  [STAGES+1];
  logic [NSTATES-1:0][MW-1:0]       metric[STAGES+1];
  logic [NSTATES-1:0][STAGES-1:0]   hist  [STAGES+1];

  // Trellis start: state 0 at zero metric, every other state unreachable.
  assign valid[0]  = in_valid_i;
  assign in_ready_o = ready[0];
  assign word[0]   = coded_word_i;
  assign hist[0]   = '0;
  always_comb begin
    for (int s = 0; s < NSTATES; s++) begin
      metric[0][s] = (s == 0) ? '0 : MW'(UNREACH);
    end
  end

  // Chain of ACS cells, one per trellis stage; each passes its survivors on.
  generate
    for (genvar g = 0; g < STAGES; g++) begin : g_cell
      vbd_cell #(
        .STAGES (STAGES),
        .IDX    (g),
        .MW     (MW)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .valid_i  (valid[g]),
        .ready_o  (ready[g]),
        .word_i   (word[g]),
        .metric_i (metric[g]),
        .hist_i   (hist[g]),
        .valid_o  (valid[g+1]),
        .ready_i  (ready[g+1]),
        .word_o   (word[g+1]),
        .metric_o (metric[g+1]),
        .hist_o   (hist[g+1])
      );
    end
  endgenerate

  // Best end state (ties to the lowest state) into the output register.
  vbd_pick #(
    .STAGES (STAGES),
    .MW     (MW)
  ) u_pick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid[STAGES]),
    .ready_o  (ready[STAGES]),
    .metric_i (metric[STAGES]),
    .hist_i   (hist[STAGES]),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .byte_o   (decoded_byte_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the rate 1/3, K=3 hard-decision Viterbi block decoder.
// Depends on vbd_pkg (widths, stage count) and viterbi_block_decoder_r13_k3_core.
`timescale 1ns / 100ps

module tb;

  import vbd_pkg::*;

  localparam int unsigned N_STAGES  = STAGES_DEF;
  localparam int unsigned LATENCY   = N_STAGES + 1;  // input transaction to result
  localparam int unsigned MAX_WAIT  = 13;            // longest gap or stall per item
  localparam int unsigned START_PM  = 0;
  localparam int unsigned UNREACHED = 3 * N_STAGES + 1;  // above any real path metric

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [WORD_W-1:0] coded_word_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [BYTE_W-1:0] decoded_byte_o;

  viterbi_block_decoder_r13_k3_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .coded_word_i   (coded_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .decoded_byte_o (decoded_byte_o)
  );

  // Decoded bytes still owed by the DUT, oldest first.
  logic [BYTE_W-1:0] pending_bytes[$];

  int unsigned words_sent;
  int unsigned bytes_checked;
  int unsigned fail_cnt;
  int unsigned sink_stall;   // cycles the sink still holds ready low
  bit          idle_on;      // random gaps and stalls enabled in this stretch

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Trellis helpers
  // ---------------------------------------------------------------------------

  // Code symbol emitted when leaving state prev with data bit b.
  // State encoding is {previous bit, current bit}.
  function automatic logic [SYM_W-1:0] branch_symbol(input logic [1:0] prev, input logic b);
    logic p1, p0;
    p1 = prev[0];
    p0 = prev[1];
    return {b ^ p1 ^ p0, p1 ^ p0, b ^ p1};
  endfunction

  // Convolutional encoder from state 0; gives clean codewords to decode.
  function automatic logic [WORD_W-1:0] encode_byte(input logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] word;
    logic [1:0]        st;
    word = '0;
    st   = 2'd0;
    for (int i = 0; i < N_STAGES; i++) begin
      word[SYM_W*i +: SYM_W] = branch_symbol(st, data[i]);
      st = {st[0], data[i]};
    end
    return word;
  endfunction

  // Predicts the decoded byte: full-length ACS with register exchange.
  function automatic logic [BYTE_W-1:0] viterbi_decode(input logic [WORD_W-1:0] word);
    int unsigned       pm[4];
    int unsigned       pm_nxt[4];
    logic [BYTE_W-1:0] surv[4];
    logic [BYTE_W-1:0] surv_nxt[4];
    logic [SYM_W-1:0]  rx;
    logic [1:0]        lo_pred, hi_pred, from;
    int unsigned       m_lo, m_hi, best;
    for (int s = 0; s < 4; s++) begin
      pm[s]   = (s == 0) ? START_PM : UNREACHED;
      surv[s] = '0;
    end
    for (int i = 0; i < N_STAGES; i++) begin
      rx = word[SYM_W*i +: SYM_W];
      for (int s = 0; s < 4; s++) begin
        // both predecessors share their low bit with the top bit of s
        lo_pred = {1'b0, s[1]};
        hi_pred = {1'b1, s[1]};
        m_lo = pm[lo_pred] + $countones(rx ^ branch_symbol(lo_pred, s[0]));
        m_hi = pm[hi_pred] + $countones(rx ^ branch_symbol(hi_pred, s[0]));
        // tie keeps the lower-numbered predecessor
        if (m_lo <= m_hi) begin
          pm_nxt[s] = m_lo;
          from      = lo_pred;
        end else begin
          pm_nxt[s] = m_hi;
          from      = hi_pred;
        end
        surv_nxt[s]    = surv[from];
        surv_nxt[s][i] = s[0];
      end
      pm   = pm_nxt;
      surv = surv_nxt;
    end
    best = 0;
    for (int s = 1; s < 4; s++) begin
      if (pm[s] < pm[best]) best = s;
    end
    return surv[best];
  endfunction

  function automatic int unsigned draw_wait();
    if (!idle_on) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: one transaction per call, driven on the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [WORD_W-1:0] word);
    int unsigned gap;
    // switch between idling and back-to-back stretches now and then
    if (words_sent % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
    gap = draw_wait();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    coded_word_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    pending_bytes.push_back(viterbi_decode(word));
    words_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: ready drops for a random stall after each result
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    sink_stall  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_stall != 0) begin
        out_ready_i <= 1'b0;
        sink_stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result checker: compares every output transaction with the oldest prediction.
  always @(posedge clk_i) begin
    logic [BYTE_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: unexpected result decoded_byte=%02h", $realtime, decoded_byte_o);
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (decoded_byte_o !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: decoded_byte mismatch: expected %02h, got %02h",
                     $realtime, want, decoded_byte_o);
        end
      end
      sink_stall = draw_wait();
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, constant symbol streams, clean and lightly corrupted codewords.
  task automatic test_directed();
    logic [BYTE_W-1:0] patterns[6];
    logic [WORD_W-1:0] all_ones;
    patterns = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80};
    all_ones = '1;
    idle_on  = 1'b0;
    send_word('0);
    send_word(all_ones);
    // every stage carries the same symbol; all-ones and all-zeros are above
    for (int v = 1; v < 7; v++) send_word({N_STAGES{v[SYM_W-1:0]}});
    send_word(24'hAAAAAA);
    send_word(24'h555555);
    foreach (patterns[k]) send_word(encode_byte(patterns[k]));
    // single bit errors at first, middle and last position
    send_word(encode_byte(8'hFF) ^ 24'h000001);
    send_word(encode_byte(8'hFF) ^ 24'h001000);
    send_word(encode_byte(8'hFF) ^ 24'h800000);
    // one whole symbol inverted, forcing metric ties along the way
    send_word(encode_byte(8'h3C) ^ 24'h000E00);
  endtask

  // Well-formed codewords with none, one or two bit errors.
  task automatic test_clean_codewords(input int unsigned count);
    logic [WORD_W-1:0] word;
    int unsigned       flips;
    repeat (count) begin
      word  = encode_byte(BYTE_W'($urandom_range(0, 255)));
      flips = $urandom_range(0, 2);
      repeat (flips) word[$urandom_range(0, WORD_W-1)] ^= 1'b1;
      send_word(word);
    end
  endtask

  // Codewords hit by scattered errors or by bursts within two adjacent symbols.
  task automatic test_noisy_codewords(input int unsigned count);
    logic [WORD_W-1:0] word;
    int unsigned       flips;
    repeat (count) begin
      word = encode_byte(BYTE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) begin
        flips = $urandom_range(3, 7);
        repeat (flips) word[$urandom_range(0, WORD_W-1)] ^= 1'b1;
      end else begin
        word ^= WORD_W'($urandom_range(1, 63)) << (SYM_W * $urandom_range(0, N_STAGES-2));
      end
      send_word(word);
    end
  endtask

  // Arbitrary words: no codeword structure at all.
  task automatic test_random_words(input int unsigned count);
    repeat (count) send_word(WORD_W'($urandom()));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned wait_cnt;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    coded_word_i  = '0;
    words_sent    = 0;
    bytes_checked = 0;
    fail_cnt      = 0;
    idle_on       = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_clean_codewords(500);
    test_noisy_codewords(400);
    test_random_words(900);

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain: bounded wait for all outstanding results, then a quiet window
    wait_cnt = 0;
    while (pending_bytes.size() != 0 && wait_cnt < 100 * (LATENCY + MAX_WAIT)) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (LATENCY + 8) @(posedge clk_i);
    if (pending_bytes.size() != 0) begin
      fail_cnt++;
      $display("%0d decoded bytes never arrived", pending_bytes.size());
    end

    $display("%0d coded words decoded (extremes, codewords with light and heavy errors,",
             words_sent);
    $display("random words), %0d results checked, %0d failures", bytes_checked, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending_bytes.size());
    $display("tb: failure");
    $finish;
  end

endmodule
